// File: design/gedh_pkg.sv
// Shared types and constants for the gray error-diffusion halftone unit.
// No dependencies; imported by the front end, back end and top module.
package gedh_pkg;

   // Configuration register map
   localparam int unsigned CSR_DATA_WIDTH  = 13;
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_WIDTH-1:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [CSR_DATA_WIDTH-1:0] IMAGE_HEIGHT_RESET = 13'd480;

   // Image geometry limits
   localparam logic [CSR_DATA_WIDTH-1:0] MIN_DIM    = 13'd3;
   localparam logic [CSR_DATA_WIDTH-1:0] MAX_HEIGHT = 13'd4096;
   localparam int unsigned ROW_BITS = 12;

   // Luma weights, unsigned with 24 fraction bits
   localparam logic [31:0] GRAY_WEIGHT_RED   = 32'd5014911;
   localparam logic [31:0] GRAY_WEIGHT_GREEN = 32'd9841699;
   localparam logic [31:0] GRAY_WEIGHT_BLUE  = 32'd1920622;

   // Floyd-Steinberg weights, in sixteenths
   localparam logic [2:0] DIFF_W_UPPER_LEFT  = 3'd1;
   localparam logic [2:0] DIFF_W_UPPER       = 3'd5;
   localparam logic [2:0] DIFF_W_UPPER_RIGHT = 3'd3;
   localparam logic [2:0] DIFF_W_LEFT        = 3'd7;

   localparam logic [7:0] BIN_THRESHOLD = 8'd128;
   localparam logic [7:0] PIXEL_MAX     = 8'd255;

   // Position class of one pixel, decided by the front end
   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic last_col;
      logic interior;
      logic frame_end;
   } pixel_flags_type;

endpackage

// File: design/gedh_fifo.sv
// Small synchronous FIFO with registered occupancy count.
// Standalone; used for the front/back queue and the result queue.
module gedh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/gedh_front.sv
// Front end: accepts RGB pixels, tracks raster position, classifies each pixel
// and converts it to gray in two stages. Depends on gedh_pkg.
module gedh_front import gedh_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int XW = $clog2(MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                red,
   input  logic [7:0]                green,
   input  logic [7:0]                blue,
   input  logic [CSR_DATA_WIDTH-1:0] image_width,
   input  logic [CSR_DATA_WIDTH-1:0] image_height,
   input  logic                      out_ready,
   output logic                      out_valid,
   output logic [7:0]                out_gray,
   output logic [XW-1:0]             out_x,
   output pixel_flags_type           out_flags
);
   localparam int WW = (XW + 1 > CSR_DATA_WIDTH) ? XW + 1 : CSR_DATA_WIDTH;

   logic [XW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [WW-1:0]       width_eff;
   logic [CSR_DATA_WIDTH-1:0] height_eff;
   pixel_flags_type     flags;
   logic                advance, accept;

   logic                s1_valid_ff;
   logic [31:0]         prod_r_ff, prod_g_ff, prod_b_ff;
   logic [XW-1:0]       s1_x_ff;
   pixel_flags_type     s1_flags_ff;

   logic                s2_valid_ff;
   logic [7:0]          s2_gray_ff;
   logic [XW-1:0]       s2_x_ff;
   pixel_flags_type     s2_flags_ff;
   logic [31:0]         luma_sum;

   assign advance = !s2_valid_ff || out_ready;
   assign full    = !advance;
   assign accept  = push && advance;

   // Clamp geometry to the supported range
   always_comb begin
      if (WW'(image_width) < WW'(MIN_DIM)) begin
         width_eff = WW'(MIN_DIM);
      end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(image_width);
      end
      if (image_height < MIN_DIM) begin
         height_eff = MIN_DIM;
      end else if (image_height > MAX_HEIGHT) begin
         height_eff = MAX_HEIGHT;
      end else begin
         height_eff = image_height;
      end
   end

   always_comb begin
      flags.x_zero    = (col_ff == '0);
      flags.y_zero    = (row_ff == '0);
      flags.last_col  = (WW'(col_ff) >= width_eff - WW'(1));
      flags.interior  = !flags.x_zero && !flags.y_zero && !flags.last_col
                        && !(CSR_DATA_WIDTH'(row_ff) >= height_eff - CSR_DATA_WIDTH'(1));
      flags.frame_end = flags.last_col
                        && (CSR_DATA_WIDTH'(row_ff) >= height_eff - CSR_DATA_WIDTH'(1));
   end

   // Advance raster position; a short row or frame wraps after its last pixel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = (CSR_DATA_WIDTH'(row_ff) >= height_eff - CSR_DATA_WIDTH'(1))
                     ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (advance) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Weighted components; the sum stays below 2^32 for all inputs
   assign luma_sum = prod_r_ff + prod_g_ff + prod_b_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_r_ff   <= 32'(red) * GRAY_WEIGHT_RED;
         prod_g_ff   <= 32'(green) * GRAY_WEIGHT_GREEN;
         prod_b_ff   <= 32'(blue) * GRAY_WEIGHT_BLUE;
         s1_x_ff     <= col_ff;
         s1_flags_ff <= flags;
         s2_gray_ff  <= luma_sum[31:24];
         s2_x_ff     <= s1_x_ff;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_gray  = s2_gray_ff;
   assign out_x     = s2_x_ff;
   assign out_flags = s2_flags_ff;

endmodule

// File: design/gedh_back.sv
// Back end: error diffusion and binarization with the row error line buffer.
// Two stages after the queue head; depends on gedh_pkg.
module gedh_back import gedh_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int XW = $clog2(MAX_WIDTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_pop,
   input  logic [7:0]      in_gray,
   input  logic [XW-1:0]   in_x,
   input  pixel_flags_type in_flags,
   input  logic            out_ready,
   output logic            out_valid,
   output logic [7:0]      out_pixel,
   output logic            out_frame_end
);
   function automatic logic [7:0] diffuse(input logic [7:0] v,
                                          input logic signed [8:0] e,
                                          input logic [2:0] k);
      logic signed [14:0] base;
      logic signed [14:0] term;
      logic signed [14:0] t;
      logic [7:0]         r;
      base = $signed({3'b000, v, 4'b0000});
      term = 15'(e) * $signed({12'd0, k});
      t    = base + term;
      if (t < 0) begin
         r = 8'd0;
      end else if (t[14:4] > 11'd255) begin
         r = PIXEL_MAX;
      end else begin
         r = t[11:4];
      end
      return r;
   endfunction

   logic signed [8:0] line_mem [MAX_WIDTH];

   logic              advance;
   logic [XW-1:0]     rd_addr;
   logic              wr_en;

   logic              s1_valid_ff;
   logic [7:0]        s1_gray_ff;
   logic [XW-1:0]     s1_x_ff;
   pixel_flags_type   s1_flags_ff;
   logic signed [8:0] mem_q_ff;
   logic              fwd_hit_ff;
   logic signed [8:0] fwd_data_ff;
   logic              rd_live_ff;

   logic              s2_valid_ff;
   logic [7:0]        s2_v_ff;
   logic [XW-1:0]     s2_x_ff;
   pixel_flags_type   s2_flags_ff;

   logic signed [8:0] left_ff;
   logic signed [8:0] upper_left_ff;
   logic signed [8:0] up_raw_ff;
   logic [XW:0]       fill_ff;

   logic signed [8:0] rd_data;
   logic signed [8:0] ul_e, up_e, ur_e, lf_e;
   logic [7:0]        v1, v2, v3, v4;
   logic [7:0]        pixel;
   logic signed [8:0] err;

   assign advance = !s2_valid_ff || out_ready;
   assign in_pop  = in_valid && advance;
   assign rd_addr = in_x + XW'(1);
   assign wr_en   = s2_valid_ff && advance;

   // Line buffer: write this pixel's error, read the upper-right entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s2_x_ff] <= err;
      end
      if (in_pop) begin
         mem_q_ff <= line_mem[rd_addr];
      end
   end

   // Entries at or beyond the fill mark were never written and read as zero
   always_ff @(posedge clock) begin
      if (in_pop) begin
         fwd_hit_ff  <= wr_en && (s2_x_ff == rd_addr);
         fwd_data_ff <= err;
         rd_live_ff  <= ((XW + 1)'(rd_addr) < fill_ff);
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_live_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data = '0;
      end
   end

   // Upper, upper-left and upper-right terms
   always_comb begin
      ul_e = (!s1_flags_ff.x_zero && !s1_flags_ff.y_zero) ? upper_left_ff : '0;
      up_e = (!s1_flags_ff.x_zero && !s1_flags_ff.y_zero) ? up_raw_ff : '0;
      ur_e = (!s1_flags_ff.y_zero && !s1_flags_ff.last_col) ? rd_data : '0;
      v1   = diffuse(s1_gray_ff, ul_e, DIFF_W_UPPER_LEFT);
      v2   = diffuse(v1, up_e, DIFF_W_UPPER);
      v3   = diffuse(v2, ur_e, DIFF_W_UPPER_RIGHT);
   end

   // Left term, then binarize interior pixels
   always_comb begin
      lf_e = s2_flags_ff.x_zero ? '0 : left_ff;
      v4   = diffuse(s2_v_ff, lf_e, DIFF_W_LEFT);
      if (s2_flags_ff.interior) begin
         if (v4 > BIN_THRESHOLD) begin
            pixel = PIXEL_MAX;
            err   = $signed({1'b0, v4}) - $signed({1'b0, PIXEL_MAX});
         end else begin
            pixel = 8'd0;
            err   = $signed({1'b0, v4});
         end
      end else begin
         pixel = v4;
         err   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff <= in_pop;
            s2_valid_ff <= s1_valid_ff;
         end
         if (wr_en && ((XW + 1)'(s2_x_ff) >= fill_ff)) begin
            fill_ff <= (XW + 1)'(s2_x_ff) + (XW + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_gray_ff  <= in_gray;
         s1_x_ff     <= in_x;
         s1_flags_ff <= in_flags;
         s2_v_ff     <= v3;
         s2_x_ff     <= s1_x_ff;
         s2_flags_ff <= s1_flags_ff;
      end
      // Carry the upper row window along with the pixel leaving the first stage
      if (advance && s1_valid_ff) begin
         upper_left_ff <= up_e;
         up_raw_ff     <= rd_data;
      end
      if (wr_en) begin
         left_ff <= err;
      end
   end

   assign out_valid     = s2_valid_ff;
   assign out_pixel     = pixel;
   assign out_frame_end = s2_flags_ff.frame_end;

endmodule

// File: design/gray_error_diffusion_halftone_unit.sv
// Gray error-diffusion halftoner: RGB in, one gray or binarized pixel out per pixel in.
// Throughput: one pixel per clock when not stalled; the left-error loop closes in the
// last back stage. Pixels pass front stages, pixel queue, back stages, result queue.
// Reset clears position counters, pipelines, queues and the line-buffer fill mark,
// and sets the image to 640 x 480; the line buffer itself needs no clearing pass.
module gray_error_diffusion_halftone_unit import gedh_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      empty,
   input  logic                      pop,
   output logic [7:0]                rsp_pixel_value,
   output logic                      rsp_frame_end,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int FB = $bits(pixel_flags_type);
   localparam int QW = XW + FB + 8;

   logic [CSR_DATA_WIDTH-1:0] image_width_ff;
   logic [CSR_DATA_WIDTH-1:0] image_height_ff;

   logic            front_valid, queue_full, queue_empty, back_pop;
   logic [7:0]      front_gray, back_gray;
   logic [XW-1:0]   front_x, back_x;
   pixel_flags_type front_flags, back_flags;
   logic [QW-1:0]   queue_in, queue_out;

   logic            back_valid, rsp_full;
   logic [7:0]      back_pixel;
   logic            back_frame_end;
   logic [8:0]      rsp_in, rsp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   gedh_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .XW        (XW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .red          (req_red),
      .green        (req_green),
      .blue         (req_blue),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .out_ready    (!queue_full),
      .out_valid    (front_valid),
      .out_gray     (front_gray),
      .out_x        (front_x),
      .out_flags    (front_flags)
   );

   assign queue_in = {front_x, front_flags, front_gray};

   gedh_fifo #(
      .WIDTH (QW),
      .DEPTH (4)
   ) u_pixel_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (queue_in),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   assign back_gray  = queue_out[7:0];
   assign back_flags = queue_out[FB+7:8];
   assign back_x     = queue_out[QW-1:FB+8];

   gedh_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .XW        (XW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (!queue_empty),
      .in_pop        (back_pop),
      .in_gray       (back_gray),
      .in_x          (back_x),
      .in_flags      (back_flags),
      .out_ready     (!rsp_full),
      .out_valid     (back_valid),
      .out_pixel     (back_pixel),
      .out_frame_end (back_frame_end)
   );

   assign rsp_in = {back_frame_end, back_pixel};

   gedh_fifo #(
      .WIDTH (9),
      .DEPTH (2)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_out),
      .empty     (empty)
   );

   assign rsp_pixel_value = rsp_out[7:0];
   assign rsp_frame_end   = rsp_out[8];

endmodule
